/* sv/sst_pkg.sv */
// Shared types, register map and constants for the servo sweep tester.
`default_nettype none

package sst_pkg;

    localparam int WORD_W  = 16;
    localparam int STEP_W  = 4;
    localparam int SHIFT_W = 4;
    localparam int LED_W   = 4;
    localparam int IDX_W   = 3;
    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;

    // Register map, one 32-bit word per register.
    typedef enum logic [IDX_W-1:0] {
        REG_PERIOD_TICKS   = 3'd0,
        REG_BASE_WIDTH     = 3'd1,
        REG_WIDTH_SPAN     = 3'd2,
        REG_DEBOUNCE_LIMIT = 3'd3,
        REG_LONG_LIMIT     = 3'd4,
        REG_SWEEP_SHIFT    = 3'd5
    } reg_idx_t;

    localparam logic [WORD_W-1:0]  RST_PERIOD_TICKS   = 16'd20000;
    localparam logic [WORD_W-1:0]  RST_BASE_WIDTH     = 16'd1000;
    localparam logic [WORD_W-1:0]  RST_WIDTH_SPAN     = 16'd1000;
    localparam logic [WORD_W-1:0]  RST_DEBOUNCE_LIMIT = 16'd10;
    localparam logic [WORD_W-1:0]  RST_LONG_LIMIT     = 16'd200;
    localparam logic [SHIFT_W-1:0] RST_SWEEP_SHIFT    = 4'd14;

    localparam logic [WORD_W-1:0] PRESS_MAX     = 16'hffff;
    localparam logic [7:0]        BLINK_ON_AT   = 8'h00;
    localparam logic [7:0]        BLINK_OFF_AT  = 8'h10;
    localparam logic [STEP_W-1:0] HIGH_STEP_MIN = 4'd3;

    typedef struct packed {
        logic [WORD_W-1:0]  period_ticks;
        logic [WORD_W-1:0]  base_width;
        logic [WORD_W-1:0]  width_span;
        logic [WORD_W-1:0]  debounce_limit;
        logic [WORD_W-1:0]  long_limit;
        logic [SHIFT_W-1:0] sweep_shift;
    } cfg_t;

    typedef struct packed {
        logic button_down;
        logic loop_step;
        logic press_step;
    } item_t;

    typedef struct packed {
        logic              servo_pulse;
        logic [LED_W-1:0]  bar_leds;
        logic              high_led;
        logic              low_led;
        logic              indicator_led;
        logic              output_enabled;
        logic [STEP_W-1:0] sweep_position;
    } result_t;

    // Step zero lights nothing; step s lights the low ((s-1) mod 4)+1 LEDs.
    function automatic logic [LED_W-1:0] led_pattern(input logic [STEP_W-1:0] s);
        logic [STEP_W-1:0] sm1;
        logic [LED_W-1:0]  pat;
        sm1 = s - 4'd1;
        case (sm1[1:0])
            2'd0:    pat = 4'b0001;
            2'd1:    pat = 4'b0011;
            2'd2:    pat = 4'b0111;
            default: pat = 4'b1111;
        endcase
        if (s == '0) begin
            pat = '0;
        end
        return pat;
    endfunction

endpackage

`default_nettype wire

/* sv/sst_cfg_regs.sv */
// APB register file holding the tester's configuration.
`default_nettype none

module sst_cfg_regs
    import sst_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.period_ticks   <= RST_PERIOD_TICKS;
            cfg_reg.base_width     <= RST_BASE_WIDTH;
            cfg_reg.width_span     <= RST_WIDTH_SPAN;
            cfg_reg.debounce_limit <= RST_DEBOUNCE_LIMIT;
            cfg_reg.long_limit     <= RST_LONG_LIMIT;
            cfg_reg.sweep_shift    <= RST_SWEEP_SHIFT;
        end else if (wr_en) begin
            case (idx)
                REG_PERIOD_TICKS:   cfg_reg.period_ticks   <= pwdata[WORD_W-1:0];
                REG_BASE_WIDTH:     cfg_reg.base_width     <= pwdata[WORD_W-1:0];
                REG_WIDTH_SPAN:     cfg_reg.width_span     <= pwdata[WORD_W-1:0];
                REG_DEBOUNCE_LIMIT: cfg_reg.debounce_limit <= pwdata[WORD_W-1:0];
                REG_LONG_LIMIT:     cfg_reg.long_limit     <= pwdata[WORD_W-1:0];
                REG_SWEEP_SHIFT:    cfg_reg.sweep_shift    <= pwdata[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (idx)
            REG_PERIOD_TICKS:   prdata[WORD_W-1:0]  = cfg_reg.period_ticks;
            REG_BASE_WIDTH:     prdata[WORD_W-1:0]  = cfg_reg.base_width;
            REG_WIDTH_SPAN:     prdata[WORD_W-1:0]  = cfg_reg.width_span;
            REG_DEBOUNCE_LIMIT: prdata[WORD_W-1:0]  = cfg_reg.debounce_limit;
            REG_LONG_LIMIT:     prdata[WORD_W-1:0]  = cfg_reg.long_limit;
            REG_SWEEP_SHIFT:    prdata[SHIFT_W-1:0] = cfg_reg.sweep_shift;
            default:            prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

/* sv/sst_width.sv */
// Pulse width for a sweep step: base + span*step/SWEEP_STEPS, saturated.
`default_nettype none

module sst_width
    import sst_pkg::*;
#(
    parameter int SWEEP_STEPS = 8
) (
    input  wire logic [STEP_W-1:0] step,
    input  wire logic [WORD_W-1:0] base_width,
    input  wire logic [WORD_W-1:0] width_span,
    output logic      [WORD_W-1:0] width
);

    // Division by SWEEP_STEPS is a multiply by a rounded-up reciprocal. With
    // span*step below 2^20 and 24 fraction bits the floor is exact.
    localparam int FRAC_BITS = 24;
    localparam int SCALE_W   = FRAC_BITS + 1;
    localparam int PROD_W    = WORD_W + SCALE_W;
    localparam longint RECIP_L =
        ((longint'(1) << FRAC_BITS) + longint'(SWEEP_STEPS) - 1) / longint'(SWEEP_STEPS);
    localparam logic [SCALE_W-1:0] RECIP = SCALE_W'(RECIP_L);

    logic [SCALE_W-1:0] scale;
    logic [PROD_W-1:0]  prod;
    logic [WORD_W-1:0]  quot;
    logic [WORD_W:0]    sum;

    always_comb begin
        // step never exceeds SWEEP_STEPS, so step*RECIP stays below 2^25.
        scale = SCALE_W'({{(SCALE_W-STEP_W){1'b0}}, step} * RECIP);
        prod  = PROD_W'({{SCALE_W{1'b0}}, width_span} * {{WORD_W{1'b0}}, scale});
        quot  = prod[FRAC_BITS +: WORD_W];
        sum   = {1'b0, base_width} + {1'b0, quot};
        width = sum[WORD_W] ? PRESS_MAX : sum[WORD_W-1:0];
    end

endmodule

`default_nettype wire

/* sv/sst_core.sv */
// Tester state and its per-tick update: button qualifier, sweep, period counter.
`default_nettype none

module sst_core
    import sst_pkg::*;
#(
    parameter int SWEEP_STEPS = 8
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    en,
    input  wire item_t   item,
    input  wire cfg_t    cfg,
    output result_t      res
);

    logic              output_on_reg,   output_on_next;
    logic [STEP_W-1:0] sweep_step_reg,  sweep_step_next;
    logic [WORD_W-1:0] pulse_width_reg, pulse_width_next;
    logic [LED_W-1:0]  led_pattern_reg, led_pattern_next;
    logic              high_flag_reg,   high_flag_next;
    logic [WORD_W-1:0] loop_ticks_reg,  loop_ticks_next;
    logic [WORD_W-1:0] press_count_reg, press_count_next;
    logic              button_prev_reg, button_prev_next;
    logic [WORD_W-1:0] frame_count_reg, frame_count_next;
    logic              blink_on_reg,    blink_on_next;
    logic              indicator_reg,   indicator_next;

    logic [STEP_W:0]   step_inc;
    logic [STEP_W-1:0] step_adv;
    logic [WORD_W-1:0] adv_width;
    logic [WORD_W-1:0] tick_mask;
    logic              sweep_due;
    logic [WORD_W-1:0] frame_mid;
    logic              pulse;

    assign step_inc  = {1'b0, sweep_step_reg} + 5'd1;
    assign step_adv  = (step_inc > (STEP_W+1)'(SWEEP_STEPS)) ? '0 : step_inc[STEP_W-1:0];
    assign tick_mask = ~({WORD_W{1'b1}} << cfg.sweep_shift);
    assign sweep_due = (loop_ticks_reg & tick_mask) == '0;

    sst_width #(
        .SWEEP_STEPS(SWEEP_STEPS)
    ) u_width (
        .step      (step_adv),
        .base_width(cfg.base_width),
        .width_span(cfg.width_span),
        .width     (adv_width)
    );

    always_comb begin
        output_on_next   = output_on_reg;
        sweep_step_next  = sweep_step_reg;
        pulse_width_next = pulse_width_reg;
        led_pattern_next = led_pattern_reg;
        high_flag_next   = high_flag_reg;
        loop_ticks_next  = loop_ticks_reg;
        press_count_next = press_count_reg;
        blink_on_next    = blink_on_reg;
        indicator_next   = indicator_reg;
        frame_mid        = frame_count_reg;

        if (item.button_down) begin
            if (item.press_step) begin
                if (press_count_reg == cfg.long_limit) begin
                    indicator_next = 1'b1;
                end
                if (press_count_reg != PRESS_MAX) begin
                    press_count_next = press_count_reg + 16'd1;
                end
            end
        end else begin
            if (button_prev_reg) begin
                if (press_count_reg > cfg.debounce_limit) begin
                    if (press_count_reg > cfg.long_limit) begin
                        output_on_next = ~output_on_reg;
                        indicator_next = 1'b0;
                    end
                    if (output_on_next) begin
                        frame_mid        = '0;
                        pulse_width_next = '0;
                    end else begin
                        led_pattern_next = '0;
                        high_flag_next   = 1'b0;
                    end
                end
                press_count_next = '0;
            end
            if (item.loop_step) begin
                if (output_on_next && sweep_due) begin
                    sweep_step_next  = step_adv;
                    pulse_width_next = adv_width;
                    led_pattern_next = led_pattern(step_adv);
                    high_flag_next   = step_adv > HIGH_STEP_MIN;
                end
                indicator_next = 1'b1;
                if (loop_ticks_reg[7:0] == BLINK_ON_AT) begin
                    blink_on_next = 1'b1;
                end
                if (loop_ticks_reg[7:0] == BLINK_OFF_AT) begin
                    blink_on_next = 1'b0;
                end
                loop_ticks_next = loop_ticks_reg + 16'd1;
            end
        end
        button_prev_next = item.button_down;

        pulse = output_on_next && (frame_mid < pulse_width_next);

        frame_count_next = frame_mid;
        if (output_on_next) begin
            if ((cfg.period_ticks != '0) && (frame_mid >= cfg.period_ticks - 16'd1)) begin
                frame_count_next = '0;
            end else begin
                frame_count_next = frame_mid + 16'd1;
            end
        end

        res.servo_pulse    = pulse;
        res.bar_leds       = blink_on_next ? led_pattern_next : '0;
        res.high_led       = blink_on_next && high_flag_next;
        res.low_led        = blink_on_next;
        res.indicator_led  = indicator_next;
        res.output_enabled = output_on_next;
        res.sweep_position = sweep_step_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            output_on_reg   <= 1'b0;
            sweep_step_reg  <= '0;
            pulse_width_reg <= '0;
            led_pattern_reg <= '0;
            high_flag_reg   <= 1'b0;
            loop_ticks_reg  <= '0;
            press_count_reg <= '0;
            button_prev_reg <= 1'b0;
            frame_count_reg <= '0;
            blink_on_reg    <= 1'b0;
            indicator_reg   <= 1'b0;
        end else if (en) begin
            output_on_reg   <= output_on_next;
            sweep_step_reg  <= sweep_step_next;
            pulse_width_reg <= pulse_width_next;
            led_pattern_reg <= led_pattern_next;
            high_flag_reg   <= high_flag_next;
            loop_ticks_reg  <= loop_ticks_next;
            press_count_reg <= press_count_next;
            button_prev_reg <= button_prev_next;
            frame_count_reg <= frame_count_next;
            blink_on_reg    <= blink_on_next;
            indicator_reg   <= indicator_next;
        end
    end

endmodule

`default_nettype wire

/* sv/servo_sweep_tester.sv */
// Servo sweep tester: a result transaction for each accepted tick.
// One input transaction is accepted every cycle while results are taken; a stalled
// result holds the input register and drops s_ready in the same cycle.
// Throughput is set by the state update, whose longest path is the
// pulse width multiply, add and compare against the period counter.
// aresetn is synchronous and active low; it empties both stages, clears the tester
// state and loads the configuration registers with their defaults.
`default_nettype none

module servo_sweep_tester
    import sst_pkg::*;
#(
    parameter int SWEEP_STEPS = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,

    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,

    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_button_down,
    input  wire logic              s_loop_step,
    input  wire logic              s_press_step,

    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_servo_pulse,
    output logic      [LED_W-1:0]  m_bar_leds,
    output logic                   m_high_led,
    output logic                   m_low_led,
    output logic                   m_indicator_led,
    output logic                   m_output_enabled,
    output logic      [STEP_W-1:0] m_sweep_position
);

    // The design has two registers in the data path. The input register
    // captures each accepted transaction; the tick is then applied to the
    // tester state and the resulting outputs are loaded into
    // the result register. Both advance together whenever the result
    // register is empty or being drained. A result that waits for m_ready
    // keeps the stored tick in the input register, so s_ready drops until
    // the result is taken.

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg;
    result_t res;
    result_t res_reg;
    logic    out_valid_reg;
    logic    advance;

    sst_cfg_regs u_cfg (
        .aclk   (aclk),
        .aresetn(aresetn),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .cfg    (cfg)
    );

    // The stored tick moves on when there is room in the result register.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // The input payload needs no reset; it is qualified by in_valid_reg.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.button_down <= s_button_down;
            item_reg.loop_step   <= s_loop_step;
            item_reg.press_step  <= s_press_step;
        end
    end

    // The core updates its state only when the tick is actually consumed,
    // so a stalled tick is never applied twice.
    sst_core #(
        .SWEEP_STEPS(SWEEP_STEPS)
    ) u_core (
        .aclk   (aclk),
        .aresetn(aresetn),
        .en     (advance),
        .item   (item_reg),
        .cfg    (cfg),
        .res    (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_servo_pulse    = res_reg.servo_pulse;
    assign m_bar_leds       = res_reg.bar_leds;
    assign m_high_led       = res_reg.high_led;
    assign m_low_led        = res_reg.low_led;
    assign m_indicator_led  = res_reg.indicator_led;
    assign m_output_enabled = res_reg.output_enabled;
    assign m_sweep_position = res_reg.sweep_position;

endmodule

`default_nettype wire

/* sv/sst_checker.sv */
// Port-level checks for the servo sweep tester and their binding.
`default_nettype none

module sst_checker
    import sst_pkg::*;
#(
    parameter int SWEEP_STEPS = 8
) (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic              m_servo_pulse,
    input wire logic [LED_W-1:0]  m_bar_leds,
    input wire logic              m_high_led,
    input wire logic              m_low_led,
    input wire logic              m_output_enabled,
    input wire logic [STEP_W-1:0] m_sweep_position
);

    // With the output off the servo pin stays low.
    a_pulse_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_output_enabled) |-> !m_servo_pulse)
        else $error("servo pulse high while output is off");

    // Outside the blink window every step LED is dark.
    a_blink_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_low_led) |-> ((m_bar_leds == '0) && !m_high_led))
        else $error("step LEDs lit outside the blink window");

    // The sweep never leaves its range.
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_sweep_position <= STEP_W'(SWEEP_STEPS)))
        else $error("sweep position out of range");

    // The high LED only lights for steps above three.
    a_high_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_high_led) |-> (m_sweep_position > HIGH_STEP_MIN))
        else $error("high LED lit at a low sweep step");

    // A stalled result stays valid and keeps its LED bar and sweep position.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_bar_leds)
                                   && $stable(m_sweep_position)))
        else $error("result changed while stalled");

endmodule

bind servo_sweep_tester sst_checker #(
    .SWEEP_STEPS(SWEEP_STEPS)
) u_sst_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_servo_pulse   (m_servo_pulse),
    .m_bar_leds      (m_bar_leds),
    .m_high_led      (m_high_led),
    .m_low_led       (m_low_led),
    .m_output_enabled(m_output_enabled),
    .m_sweep_position(m_sweep_position)
);

`default_nettype wire
